### src/kclc_pkg.sv
// kclc_pkg: shared types and constants for the keypad code lock controller
// no dependencies; imported by kclc_engine and keypad_code_lock_controller_unit
package kclc_pkg;

	// operating modes
	typedef enum logic [2:0] {
		MODE_MENU  = 3'd0,
		MODE_ENTRY = 3'd1,
		MODE_OLD   = 3'd2,
		MODE_NEW   = 3'd3,
		MODE_OPEN  = 3'd4,
		MODE_ALARM = 3'd5
	} mode_t;

	// event codes reported with each result word
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_SYMBOL  = 3'd1,
		EV_DELETE  = 3'd2,
		EV_WRONG   = 3'd3,
		EV_OPENED  = 3'd4,
		EV_CHANGED = 3'd5,
		EV_CLOSED  = 3'd6,
		EV_ALARM   = 3'd7
	} event_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MAX_ATTEMPTS     = 3'd0,
		REG_ALARM_TICKS      = 3'd1,
		REG_TOGGLE_TICKS     = 3'd2,
		REG_KEY_BEEP_TICKS   = 3'd3,
		REG_ALARM_BEEP_TICKS = 3'd4,
		REG_MIN_CODE_LENGTH  = 3'd5
	} reg_index_t;

	// key codes with a meaning of their own
	localparam logic [3:0] KEY_A    = 4'd10;
	localparam logic [3:0] KEY_B    = 4'd11;
	localparam logic [3:0] KEY_C    = 4'd12;
	localparam logic [3:0] KEY_D    = 4'd13;
	localparam logic [3:0] KEY_HASH = 4'd15;

	// item kinds
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// configuration reset values
	localparam logic [3:0]  RST_MAX_ATTEMPTS     = 4'd3;
	localparam logic [15:0] RST_ALARM_TICKS      = 16'd10000;
	localparam logic [15:0] RST_TOGGLE_TICKS     = 16'd200;
	localparam logic [15:0] RST_KEY_BEEP_TICKS   = 16'd20;
	localparam logic [15:0] RST_ALARM_BEEP_TICKS = 16'd100;
	localparam logic [2:0]  RST_MIN_CODE_LENGTH  = 3'd4;

	// length of the code stored after reset (123456)
	localparam int RST_CODE_LEN = 6;

	typedef struct packed {
		logic [3:0]  max_attempts;
		logic [15:0] alarm_ticks;
		logic [15:0] toggle_ticks;
		logic [15:0] key_beep_ticks;
		logic [15:0] alarm_beep_ticks;
		logic [2:0]  min_code_length;
	} cfg_t;

	typedef struct packed {
		event_t     event_res;
		logic       alarm_on;
		logic [3:0] attempts_left;
		logic [2:0] entered_count;
		logic       buzzer_on;
		logic       led_green;
		mode_t      ui_mode;
	} res_t;

endpackage

### src/kclc_engine.sv
// kclc_engine: lock state (mode, entry buffer, stored code, timers) and the
// combinational update for one key or tick word; depends on kclc_pkg
module kclc_engine import kclc_pkg::*; #(
	parameter int CODE_DEPTH = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       op,
	input  logic [3:0] key,
	input  cfg_t       cfg,
	output res_t       res
);

	localparam int LEN_W = $clog2(CODE_DEPTH + 1);
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(CODE_DEPTH);
	localparam logic [LEN_W-1:0] RST_LEN =
		LEN_W'((CODE_DEPTH < RST_CODE_LEN) ? CODE_DEPTH : RST_CODE_LEN);

	mode_t            mode_q, mode_d;
	logic [3:0]       entry_q [CODE_DEPTH];
	logic [3:0]       entry_d [CODE_DEPTH];
	logic [3:0]       code_q  [CODE_DEPTH];
	logic [3:0]       code_d  [CODE_DEPTH];
	logic [LEN_W-1:0] elen_q, elen_d;
	logic [LEN_W-1:0] clen_q, clen_d;
	logic [3:0]       attempts_q, attempts_d;
	logic             running_q, running_d;
	logic [15:0]      alarm_rem_q, alarm_rem_d;
	logic [15:0]      toggle_rem_q, toggle_rem_d;
	logic             phase_q, phase_d;
	logic [15:0]      buzz_q, buzz_d;
	logic             green_q, green_d;
	event_t           ev;
	logic             match;

	// entered code equals stored code
	always_comb begin
		match = (elen_q == clen_q);
		for (int i = 0; i < CODE_DEPTH; i++) begin
			if ((LEN_W'(i) < clen_q) && (entry_q[i] != code_q[i]))
				match = 1'b0;
		end
	end

	always_comb begin
		mode_d       = mode_q;
		entry_d      = entry_q;
		code_d       = code_q;
		elen_d       = elen_q;
		clen_d       = clen_q;
		attempts_d   = attempts_q;
		running_d    = running_q;
		alarm_rem_d  = alarm_rem_q;
		toggle_rem_d = toggle_rem_q;
		phase_d      = phase_q;
		buzz_d       = buzz_q;
		green_d      = green_q;
		ev           = EV_NONE;

		if (op == OP_TICK) begin
			if (buzz_q != 16'd0)
				buzz_d = buzz_q - 16'd1;
			if (running_q) begin
				if (alarm_rem_q == 16'd0) begin
					running_d = 1'b0;
					buzz_d    = 16'd0;
					green_d   = 1'b0;
				end else begin
					alarm_rem_d = alarm_rem_q - 16'd1;
					if (toggle_rem_q == 16'd0) begin
						toggle_rem_d = cfg.toggle_ticks;
						green_d      = ~phase_q;
						phase_d      = ~phase_q;
						buzz_d       = cfg.alarm_beep_ticks;
					end else begin
						toggle_rem_d = toggle_rem_q - 16'd1;
					end
				end
			end
		end else begin
			buzz_d = cfg.key_beep_ticks;
			unique case (mode_q)
				MODE_MENU: begin
					if (key == KEY_A)
						mode_d = MODE_ENTRY;
					else if (key == KEY_B)
						mode_d = MODE_OLD;
				end
				MODE_ENTRY, MODE_OLD, MODE_NEW, MODE_ALARM: begin
					priority if (key == KEY_HASH && mode_q != MODE_ALARM) begin
						elen_d = '0;
						mode_d = MODE_MENU;
					end else if (key == KEY_D && mode_q == MODE_NEW) begin
						// accept the new code if long enough
						if (elen_q >= LEN_W'(cfg.min_code_length)) begin
							code_d = entry_q;
							clen_d = elen_q;
							elen_d = '0;
							mode_d = MODE_MENU;
							ev     = EV_CHANGED;
						end
					end else if (key == KEY_D && mode_q == MODE_ALARM) begin
						elen_d = '0;
						if (match) begin
							attempts_d  = cfg.max_attempts;
							alarm_rem_d = 16'd0;
							mode_d      = MODE_MENU;
						end else begin
							running_d    = 1'b1;
							phase_d      = 1'b0;
							alarm_rem_d  = cfg.alarm_ticks;
							toggle_rem_d = 16'd0;
							ev           = EV_ALARM;
						end
					end else if (key == KEY_D) begin
						elen_d = '0;
						if (!match) begin
							if (attempts_q <= 4'd1) begin
								attempts_d   = 4'd0;
								mode_d       = MODE_ALARM;
								running_d    = 1'b1;
								phase_d      = 1'b0;
								alarm_rem_d  = cfg.alarm_ticks;
								toggle_rem_d = 16'd0;
								ev           = EV_ALARM;
							end else begin
								attempts_d = attempts_q - 4'd1;
								ev         = EV_WRONG;
							end
						end else if (mode_q == MODE_OLD) begin
							mode_d = MODE_NEW;
						end else begin
							attempts_d = cfg.max_attempts;
							green_d    = 1'b1;
							mode_d     = MODE_OPEN;
							ev         = EV_OPENED;
						end
					end else if (key == KEY_C) begin
						if (elen_q != '0) begin
							elen_d = elen_q - LEN_W'(1);
							ev     = EV_DELETE;
						end
					end else if (elen_q < DEPTH_LEN) begin
						// append symbol at the current length
						for (int i = 0; i < CODE_DEPTH; i++) begin
							if (elen_q == LEN_W'(i))
								entry_d[i] = key;
						end
						elen_d = elen_q + LEN_W'(1);
						ev     = EV_SYMBOL;
					end
				end
				MODE_OPEN: begin
					if (key == KEY_D) begin
						green_d = 1'b0;
						mode_d  = MODE_MENU;
						ev      = EV_CLOSED;
					end
				end
				default: begin
					ev = EV_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_MENU;
			elen_q       <= '0;
			clen_q       <= RST_LEN;
			attempts_q   <= RST_MAX_ATTEMPTS;
			running_q    <= 1'b0;
			alarm_rem_q  <= 16'd0;
			toggle_rem_q <= 16'd0;
			phase_q      <= 1'b0;
			buzz_q       <= 16'd0;
			green_q      <= 1'b0;
			for (int i = 0; i < CODE_DEPTH; i++) begin
				entry_q[i] <= 4'd0;
				code_q[i]  <= (i < RST_CODE_LEN) ? 4'(i + 1) : 4'd0;
			end
		end else if (step) begin
			mode_q       <= mode_d;
			elen_q       <= elen_d;
			clen_q       <= clen_d;
			attempts_q   <= attempts_d;
			running_q    <= running_d;
			alarm_rem_q  <= alarm_rem_d;
			toggle_rem_q <= toggle_rem_d;
			phase_q      <= phase_d;
			buzz_q       <= buzz_d;
			green_q      <= green_d;
			entry_q      <= entry_d;
			code_q       <= code_d;
		end
	end

	// result reflects the state after this word
	always_comb begin
		res.ui_mode       = mode_d;
		res.led_green     = green_d;
		res.buzzer_on     = (buzz_d != 16'd0);
		res.entered_count = elen_d[2:0];
		res.attempts_left = attempts_d;
		res.alarm_on      = running_d;
		res.event_res     = ev;
	end

endmodule

### src/keypad_code_lock_controller_unit.sv
// keypad_code_lock_controller_unit: top level with stream ports, input and
// result registers and configuration registers; depends on kclc_pkg, kclc_engine
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata key_code, s_tuser operation
//  m_      | out       | m_tvalid/m_tready  | m_tdata result fields
//  cfg_    | in        | cfg_we (no wait)   | cfg_addr, cfg_wdata
//
// a word sits in the input register; the engine updates the lock state and
// the result register in the same cycle
// an accepted word passes the input register, then the result register; a
// word per cycle while m_tready stays high
// when the result waits, one more word is held in the input register
// asynchronous reset puts the lock in menu with code 123456 and the
// configuration at its defaults
module keypad_code_lock_controller_unit import kclc_pkg::*; #(
	parameter int CODE_DEPTH = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] key_code, [7:4] zero
	input  logic        s_tuser,   // [0] operation (0 key, 1 tick)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [2:0] ui_mode, [3] led_green, [4] buzzer_on,
	                               // [7:5] entered_count, [11:8] attempts_left,
	                               // [12] alarm_on, [15:13] event_res
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       op_s1;
	logic [3:0] key_s1;
	logic       out_valid_q;
	res_t       res_q;
	res_t       res_next;
	logic       advance;
	logic       load;

	// word in the input register moves on when the result slot is free
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign load     = s_tvalid && s_tready;

	// configuration registers, out-of-range indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_attempts     <= RST_MAX_ATTEMPTS;
			cfg_q.alarm_ticks      <= RST_ALARM_TICKS;
			cfg_q.toggle_ticks     <= RST_TOGGLE_TICKS;
			cfg_q.key_beep_ticks   <= RST_KEY_BEEP_TICKS;
			cfg_q.alarm_beep_ticks <= RST_ALARM_BEEP_TICKS;
			cfg_q.min_code_length  <= RST_MIN_CODE_LENGTH;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MAX_ATTEMPTS:     cfg_q.max_attempts     <= cfg_wdata[3:0];
				REG_ALARM_TICKS:      cfg_q.alarm_ticks      <= cfg_wdata;
				REG_TOGGLE_TICKS:     cfg_q.toggle_ticks     <= cfg_wdata;
				REG_KEY_BEEP_TICKS:   cfg_q.key_beep_ticks   <= cfg_wdata;
				REG_ALARM_BEEP_TICKS: cfg_q.alarm_beep_ticks <= cfg_wdata;
				REG_MIN_CODE_LENGTH:  cfg_q.min_code_length  <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_s1  <= s_tuser;
			key_s1 <= s_tdata[3:0];
		end
	end

	kclc_engine #(
		.CODE_DEPTH(CODE_DEPTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.op     (op_s1),
		.key    (key_s1),
		.cfg    (cfg_q),
		.res    (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_next;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.event_res, res_q.alarm_on, res_q.attempts_left,
	                   res_q.entered_count, res_q.buzzer_on, res_q.led_green,
	                   res_q.ui_mode};

endmodule
